@@ design/hcr_pkg.sv @@
// ----------------------------------------------------------------------------
// hcr_pkg
// Types, sizes and constant tables for the harmonic calibrate and
// resynthesize core.
// ----------------------------------------------------------------------------
package hcr_pkg;

  localparam int MAX_COMPONENTS = 8;
  localparam int REBUILD_POINTS = 2048;
  localparam int CAL_POINTS     = 13;

  localparam int CNT_W  = $clog2(MAX_COMPONENTS + 1);
  localparam int ADDR_W = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
  localparam int PTS_W  = $clog2(REBUILD_POINTS);
  localparam int ANG_SH = 16 - PTS_W;
  localparam int SEG_W  = $clog2(CAL_POINTS);

  localparam int GAIN_W = 22;
  localparam int DIFF_W = 17;
  localparam int DG_W   = 18;
  localparam int DEN_W  = 17;
  localparam int NUM_W  = DIFF_W + DG_W;

  localparam logic [19:0] KNOT_FREQ [CAL_POINTS] = '{
    20'd10000,  20'd25000,  20'd50000,  20'd100000, 20'd200000,
    20'd250000, 20'd300000, 20'd350000, 20'd400000, 20'd425000,
    20'd450000, 20'd475000, 20'd500000
  };

  localparam logic [GAIN_W-1:0] KNOT_GAIN [CAL_POINTS] = '{
    22'd2286516, 22'd2291499, 22'd2294150, 22'd2311766, 22'd2344381,
    22'd2341076, 22'd2318695, 22'd2257207, 22'd2150554, 22'd2102856,
    22'd2075224, 22'd2110792, 22'd2269202
  };

  localparam logic [30:0] SIN_SEED = 31'd172272;
  localparam logic [30:0] SIN_COEF [4] = '{
    31'd5026995, 31'd85569306, 31'd693598669, 31'd1686629713
  };

  typedef struct packed {
    logic [7:0]         harmonic_no;
    logic [19:0]        freq_hz;
    logic [19:0]        peak_code;
    logic [19:0]        rms_level_code;
    logic signed [15:0] abs_phase;
    logic               final_component;
  } item_t;

  typedef struct packed {
    logic               kind;
    logic [4:0]         comp_index;
    logic [17:0]        peak_mv;
    logic [17:0]        rms_mv;
    logic signed [15:0] rel_angle;
    logic [17:0]        total_rms_mv;
    logic [19:0]        peak_to_peak_mv;
    logic signed [19:0] rebuilt_min_mv;
    logic signed [19:0] rebuilt_max_mv;
    logic               error;
    logic               end_of_run;
  } result_t;

endpackage

@@ design/harmonic_calibrate_and_resynthesize_core.sv @@
// ----------------------------------------------------------------------------
// harmonic_calibrate_and_resynthesize_core
// Calibrates spectral components one beat at a time and, after the final
// component, rebuilds one zero-phase period and reports RMS, min, max and
// peak-to-peak.
//
// Each result is shown for one cycle on result_o with result_valid_o and
// the receiver cannot stall it. A component's gain comes from the 35-step
// restoring divider of the gain interpolation, skipped when its frequency
// lies outside the table; busy is high meanwhile. A final component then
// adds a square root and a rebuild of REBUILD_POINTS points, each summing
// the stored components (at most MAX_COMPONENTS) through the sine pipeline,
// one stored component read from the component memory per cycle. The summary
// follows the component's own result.
// ----------------------------------------------------------------------------
module harmonic_calibrate_and_resynthesize_core
  import hcr_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  input  item_t   item_i,
  output logic    busy,
  output logic    result_valid_o,
  output result_t result_o
);

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b0000_0000_0001,
    ST_GAIN  = 12'b0000_0000_0010,
    ST_MUL   = 12'b0000_0000_0100,
    ST_DIV   = 12'b0000_0000_1000,
    ST_GADD  = 12'b0000_0001_0000,
    ST_PK    = 12'b0000_0010_0000,
    ST_RM    = 12'b0000_0100_0000,
    ST_SQ    = 12'b0000_1000_0000,
    ST_ACC   = 12'b0001_0000_0000,
    ST_ROOT  = 12'b0010_0000_0000,
    ST_BUILD = 12'b0100_0000_0000,
    ST_DRAIN = 12'b1000_0000_0000
  } state_e;

  typedef struct packed {
    logic v;
    logic first;
    logic lastp;
    logic fpt;
    logic lastall;
  } meta_t;

  state_e state_q;
  item_t  in_q;
  result_t res_q;
  logic    res_valid_q;

  logic [CNT_W-1:0]  cnt_q;
  logic [15:0]       base_q;
  logic [39:0]       psum_q;
  logic              ovf_q;

  logic [SEG_W-1:0]  seg_q;
  logic [NUM_W-1:0]  num_q;
  logic [DEN_W-1:0]  den_q;
  logic [DEN_W-1:0]  rem_q;
  logic              dneg_q;
  logic [5:0]        it_q;
  logic [GAIN_W-1:0] gain_q;
  logic [17:0]       pk_q;
  logic [17:0]       rm_q;
  logic [35:0]       sq_q;
  logic [15:0]       rel_q;

  logic [39:0]       r_q;
  logic [39:0]       bit_q;
  logic [17:0]       tr_q;

  logic [PTS_W-1:0]  n_q;
  logic [ADDR_W-1:0] i_q;
  meta_t             meta_q [0:8];
  logic signed [39:0] acc_q;
  logic signed [24:0] hi_q;
  logic signed [24:0] lo_q;
  logic              done_q;

  // component memory
  logic [17:0] pk_mem [MAX_COMPONENTS];
  logic [7:0]  h_mem  [MAX_COMPONENTS];
  logic [17:0] rd_pk_q;
  logic [7:0]  rd_h_q;
  logic [PTS_W-1:0] n1_q;

  // sine pipeline
  logic [30:0] z_q   [1:6];
  logic [30:0] z2_q  [2:5];
  logic [30:0] t_q   [3:6];
  logic        neg_q [1:6];
  logic [17:0] pkp_q [1:7];
  logic signed [15:0] sine_q;
  logic signed [34:0] prod_q;

  // gain segment search
  logic [SEG_W-1:0] seg_w;
  logic             f_low, f_high;
  always_comb begin
    seg_w = '0;
    for (int k = CAL_POINTS - 2; k >= 0; k--) begin
      if (in_q.freq_hz <= KNOT_FREQ[k+1]) begin
        seg_w = SEG_W'(k);
      end
    end
  end
  assign f_low  = in_q.freq_hz <= KNOT_FREQ[0];
  assign f_high = in_q.freq_hz >= KNOT_FREQ[CAL_POINTS-1];

  logic [SEG_W-1:0]    seg_nx;
  logic [DIFF_W-1:0]   diff_w;
  logic signed [GAIN_W:0] dg_w;
  logic [DG_W-1:0]     dg_mag;
  logic [NUM_W-1:0]    num_w;
  logic [DEN_W-1:0]    den_w;
  assign seg_nx = seg_q + 1'b1;
  assign diff_w = DIFF_W'(in_q.freq_hz - KNOT_FREQ[seg_q]);
  assign dg_w   = signed'({1'b0, KNOT_GAIN[seg_nx]}) - signed'({1'b0, KNOT_GAIN[seg_q]});
  assign dg_mag = DG_W'(dg_w[GAIN_W] ? -dg_w : dg_w);
  assign num_w  = diff_w * dg_mag;
  assign den_w  = DEN_W'(KNOT_FREQ[seg_nx] - KNOT_FREQ[seg_q]);

  logic [DEN_W:0] rem_sh;
  logic           rem_ge;
  assign rem_sh = {rem_q, num_q[NUM_W-1]};
  assign rem_ge = rem_sh >= {1'b0, den_q};

  logic signed [GAIN_W+1:0] quo_s;
  logic signed [GAIN_W+1:0] gsum_w;
  assign quo_s  = signed'({{(GAIN_W + 2 - DG_W){1'b0}}, num_q[DG_W-1:0]});
  assign gsum_w = signed'({2'b00, KNOT_GAIN[seg_q]}) + (dneg_q ? -quo_s : quo_s);

  // code times gain, rounded and saturated
  logic [19:0] code_w;
  logic [42:0] scl_w;
  logic [17:0] scl_sat;
  assign code_w  = state_q == ST_PK ? in_q.peak_code : in_q.rms_level_code;
  assign scl_w   = 43'(code_w) * 43'(gain_q) + (43'(1) << 23);
  assign scl_sat = (scl_w[42:24] > 19'd262143) ? '1 : scl_w[41:24];

  logic [15:0] base_sel;
  assign base_sel = (cnt_q == '0) ? in_q.abs_phase : base_q;

  logic [40:0] psum_add;
  assign psum_add = {1'b0, psum_q} + 41'(sq_q);

  // square root step
  logic [40:0] rt_try;
  logic        rt_ge;
  logic [39:0] r_nx;
  assign rt_try = {1'b0, r_q} + {1'b0, bit_q};
  assign rt_ge  = {1'b0, psum_q} >= rt_try;
  assign r_nx   = rt_ge ? (r_q >> 1) + bit_q : r_q >> 1;

  logic lastp_w, lastall_w;
  assign lastp_w   = i_q == ADDR_W'(cnt_q - 1'b1);
  assign lastall_w = lastp_w && (n_q == '1);

  // accumulation of one rebuilt point
  logic signed [39:0] acc_sum;
  logic signed [39:0] acc_rnd;
  logic signed [24:0] w_w;
  assign acc_sum = (meta_q[8].first ? 40'sd0 : acc_q) + 40'(prod_q);
  assign acc_rnd = acc_sum + 40'sd16384;
  assign w_w     = acc_rnd[39:15];

  logic signed [25:0] pp_w;
  logic [19:0]        pp_sat;
  logic signed [19:0] lo_sat, hi_sat;
  assign pp_w   = 26'(hi_q) - 26'(lo_q);
  assign pp_sat = (pp_w > 26'sd1048575) ? 20'hFFFFF : pp_w[19:0];
  assign lo_sat = (lo_q > 25'sd524287) ? 20'sh7FFFF :
                  (lo_q < -25'sd524288) ? 20'sh80000 : lo_q[19:0];
  assign hi_sat = (hi_q > 25'sd524287) ? 20'sh7FFFF :
                  (hi_q < -25'sd524288) ? 20'sh80000 : hi_q[19:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_valid_q <= 1'b0;
      res_q       <= '0;
      in_q        <= '0;
      cnt_q       <= '0;
      base_q      <= '0;
      psum_q      <= '0;
      ovf_q       <= 1'b0;
      seg_q       <= '0;
      num_q       <= '0;
      den_q       <= '0;
      rem_q       <= '0;
      dneg_q      <= 1'b0;
      it_q        <= '0;
      gain_q      <= '0;
      pk_q        <= '0;
      rm_q        <= '0;
      sq_q        <= '0;
      rel_q       <= '0;
      r_q         <= '0;
      bit_q       <= '0;
      tr_q        <= '0;
      n_q         <= '0;
      i_q         <= '0;
      acc_q       <= '0;
      hi_q        <= '0;
      lo_q        <= '0;
      done_q      <= 1'b0;
      for (int k = 0; k <= 8; k++) begin
        meta_q[k] <= '0;
      end
    end else begin
      res_valid_q <= (state_q == ST_GAIN && cnt_q == CNT_W'(MAX_COMPONENTS)) ||
                     state_q == ST_ACC || (state_q == ST_DRAIN && done_q);

      meta_q[0] <= '{v: state_q == ST_BUILD, first: i_q == '0, lastp: lastp_w,
                     fpt: n_q == '0, lastall: lastall_w};
      for (int k = 1; k <= 8; k++) begin
        meta_q[k] <= meta_q[k-1];
      end

      if (meta_q[8].v) begin
        acc_q <= acc_sum;
        if (meta_q[8].lastp) begin
          if (meta_q[8].fpt || w_w < lo_q) begin
            lo_q <= w_w;
          end
          if (meta_q[8].fpt || w_w > hi_q) begin
            hi_q <= w_w;
          end
        end
        if (meta_q[8].lastall) begin
          done_q <= 1'b1;
        end
      end

      case (state_q)
        ST_IDLE: begin
          if (start) begin
            in_q    <= item_i;
            state_q <= ST_GAIN;
          end
        end
        ST_GAIN: begin
          if (cnt_q == CNT_W'(MAX_COMPONENTS)) begin
            ovf_q <= 1'b1;
            res_q <= '{comp_index: 5'(cnt_q), error: 1'b1,
                       end_of_run: !in_q.final_component, default: '0};
            if (in_q.final_component) begin
              r_q     <= '0;
              bit_q   <= 40'(1) << 38;
              state_q <= ST_ROOT;
            end else begin
              state_q <= ST_IDLE;
            end
          end else if (f_low) begin
            gain_q  <= KNOT_GAIN[0];
            state_q <= ST_PK;
          end else if (f_high) begin
            gain_q  <= KNOT_GAIN[CAL_POINTS-1];
            state_q <= ST_PK;
          end else begin
            seg_q   <= seg_w;
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          num_q   <= num_w;
          den_q   <= den_w;
          dneg_q  <= dg_w[GAIN_W];
          rem_q   <= '0;
          it_q    <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (rem_ge) begin
            rem_q <= DEN_W'(rem_sh - {1'b0, den_q});
            num_q <= {num_q[NUM_W-2:0], 1'b1};
          end else begin
            rem_q <= rem_sh[DEN_W-1:0];
            num_q <= {num_q[NUM_W-2:0], 1'b0};
          end
          it_q <= it_q + 1'b1;
          if (it_q == 6'(NUM_W - 1)) begin
            state_q <= ST_GADD;
          end
        end
        ST_GADD: begin
          gain_q  <= GAIN_W'(gsum_w);
          state_q <= ST_PK;
        end
        ST_PK: begin
          pk_q    <= scl_sat;
          state_q <= ST_RM;
        end
        ST_RM: begin
          rm_q    <= scl_sat;
          state_q <= ST_SQ;
        end
        ST_SQ: begin
          sq_q    <= rm_q * rm_q;
          rel_q   <= in_q.abs_phase - 16'(16'(in_q.harmonic_no) * base_sel);
          state_q <= ST_ACC;
        end
        ST_ACC: begin
          psum_q <= psum_add[40] ? '1 : psum_add[39:0];
          if (cnt_q == '0) begin
            base_q <= in_q.abs_phase;
          end
          cnt_q <= cnt_q + 1'b1;
          res_q <= '{comp_index: 5'(cnt_q), peak_mv: pk_q, rms_mv: rm_q,
                     rel_angle: rel_q, end_of_run: !in_q.final_component,
                     default: '0};
          if (in_q.final_component) begin
            r_q     <= '0;
            bit_q   <= 40'(1) << 38;
            state_q <= ST_ROOT;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_ROOT: begin
          if (rt_ge) begin
            psum_q <= psum_q - rt_try[39:0];
          end
          r_q   <= r_nx;
          bit_q <= bit_q >> 2;
          if (bit_q[0]) begin
            tr_q    <= (r_nx > 40'd262143) ? '1 : r_nx[17:0];
            n_q     <= '0;
            i_q     <= '0;
            state_q <= ST_BUILD;
          end
        end
        ST_BUILD: begin
          if (lastp_w) begin
            i_q <= '0;
            n_q <= n_q + 1'b1;
          end else begin
            i_q <= i_q + 1'b1;
          end
          if (lastall_w) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (done_q) begin
            done_q  <= 1'b0;
            res_q   <= '{kind: 1'b1, total_rms_mv: tr_q, peak_to_peak_mv: pp_sat,
                         rebuilt_min_mv: lo_sat, rebuilt_max_mv: hi_sat,
                         error: ovf_q, end_of_run: 1'b1, default: '0};
            cnt_q   <= '0;
            base_q  <= '0;
            psum_q  <= '0;
            ovf_q   <= 1'b0;
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_RM) begin
      pk_mem[cnt_q[ADDR_W-1:0]] <= pk_q;
      h_mem[cnt_q[ADDR_W-1:0]]  <= in_q.harmonic_no;
    end
    rd_pk_q <= pk_mem[i_q];
    rd_h_q  <= h_mem[i_q];
  end

  // sine of the folded angle, odd polynomial in q30
  logic [20:0] hn_w;
  logic [20:0] hn_sh;
  logic [15:0] ang_w;
  logic [14:0] q_w;
  logic [61:0] zz_w;
  logic [61:0] tp_w [3:6];
  logic [61:0] zt_w;
  logic [32:0] s_add;
  logic [17:0] s_r;
  logic [14:0] s_c;

  assign hn_w  = 21'(rd_h_q) * 21'(n1_q);
  assign hn_sh = hn_w << ANG_SH;
  assign ang_w = hn_sh[15:0];
  assign q_w   = ang_w[14] ? 15'(15'd16384 - {1'b0, ang_w[13:0]}) : {1'b0, ang_w[13:0]};
  assign zz_w  = z_q[1] * z_q[1];
  assign tp_w[3] = z2_q[2] * SIN_SEED;
  assign tp_w[4] = z2_q[3] * t_q[3];
  assign tp_w[5] = z2_q[4] * t_q[4];
  assign tp_w[6] = z2_q[5] * t_q[5];
  assign zt_w  = z_q[6] * t_q[6];
  assign s_add = {1'b0, zt_w[61:30]} + 33'd16384;
  assign s_r   = s_add[32:15];
  assign s_c   = (s_r > 18'd32767) ? 15'h7FFF : s_r[14:0];

  always_ff @(posedge clk_i) begin
    n1_q     <= n_q;
    z_q[1]   <= {q_w, 16'b0};
    neg_q[1] <= ang_w[15];
    pkp_q[1] <= rd_pk_q;
    for (int k = 2; k <= 6; k++) begin
      z_q[k]   <= z_q[k-1];
      neg_q[k] <= neg_q[k-1];
    end
    for (int k = 2; k <= 7; k++) begin
      pkp_q[k] <= pkp_q[k-1];
    end
    z2_q[2] <= zz_w[60:30];
    for (int k = 3; k <= 5; k++) begin
      z2_q[k] <= z2_q[k-1];
    end
    for (int k = 3; k <= 6; k++) begin
      t_q[k] <= 31'(32'(SIN_COEF[k-3]) - tp_w[k][61:30]);
    end
    sine_q <= neg_q[6] ? -signed'({1'b0, s_c}) : signed'({1'b0, s_c});
    prod_q <= signed'({1'b0, pkp_q[7]}) * sine_q;
  end

  assign busy           = state_q != ST_IDLE;
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule
